/* design/utfs_pkg.sv */
package utfs_pkg;

  localparam int RUN_MAX       = 5;
  localparam int RUN_CNT_W     = $clog2(RUN_MAX + 1);
  localparam int QUEUE_DEPTH_D = 2;

  localparam logic [7:0]  REPL_HI    = 8'hC2;
  localparam logic [7:0]  REPL_LO    = 8'hBF;
  localparam logic [20:0] CODE_MIN   = 21'h000080;
  localparam logic [20:0] CODE_MAX   = 21'h10FFFF;
  localparam logic [7:0]  CONT_MASK  = 8'hC0;
  localparam logic [7:0]  CONT_MARK  = 8'h80;
  localparam logic [7:0]  PAYLD_MASK = 8'h3F;

  // Bytes caused by one input transaction, oldest in bytes[0]
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_CNT_W-1:0]    count;
  } run_t;

  localparam int RUN_W = $bits(run_t);

endpackage

/* design/utf8_sanitizer.sv */
// Channel | Handshake            | Payload
// input   | in_valid / in_ready  | data_byte[7:0], end_of_stream
// output  | out_valid / out_ready| out_byte[7:0], last_of_run
//
// An input byte is classified in the cycle it is accepted; its result bytes
// (0 to 5) enter a QUEUE_DEPTH-entry run queue at the same edge.
// The output side sends one byte per cycle while out_ready is high, so an
// input with k result bytes occupies it until all k are sent; input is taken
// every cycle while the queue has room. Reset clears the sequence state and
// empties the queue; output stalls hold the head byte.
module utf8_sanitizer #(
  parameter int QUEUE_DEPTH = utfs_pkg::QUEUE_DEPTH_D
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import utfs_pkg::*;

  logic q_full, q_empty, push, pop;
  run_t push_run, head_run;

  utfs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .q_full        (q_full),
    .push          (push),
    .push_run      (push_run)
  );

  utfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head_run (head_run)
  );

  utfs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head_run    (head_run),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

/* design/utfs_front.sv */
module utfs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          end_of_stream,
  input  logic          q_full,
  output logic          push,
  output utfs_pkg::run_t push_run
);
  import utfs_pkg::*;

  logic                 active, active_next;
  logic [3:0][7:0]      seq_buf, seq_buf_next;
  logic [2:0]           seq_len, seq_len_next;
  logic [2:0]           cont_left, cont_left_next;
  logic [20:0]          code_val, code_val_next;
  logic                 overflow, overflow_next;
  run_t                 run;
  logic                 cont;
  logic                 take;

  function automatic run_t emit_byte(run_t r, logic [7:0] b);
    run_t res;
    res = r;
    if (res.count < RUN_CNT_W'(RUN_MAX)) begin
      res.bytes[res.count] = b;
      res.count = res.count + RUN_CNT_W'(1);
    end
    return res;
  endfunction

  function automatic run_t flush_run(run_t r, logic [3:0][7:0] bufv, logic [2:0] len,
                                     logic [2:0] cl, logic [20:0] code, logic ovf);
    run_t res;
    logic ok;
    res = r;
    ok  = (cl == 3'd1) && !ovf && (code >= CODE_MIN) && (code <= CODE_MAX);
    if (ok) begin
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < len) res = emit_byte(res, bufv[k]);
      end
    end else begin
      res = emit_byte(res, REPL_HI);
      res = emit_byte(res, REPL_LO);
    end
    return res;
  endfunction

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign cont     = (data_byte & CONT_MASK) == CONT_MARK;

  always_comb begin
    active_next    = active;
    seq_buf_next   = seq_buf;
    seq_len_next   = seq_len;
    cont_left_next = cont_left;
    code_val_next  = code_val;
    overflow_next  = overflow;
    run            = '0;

    // Held lead byte that could not be flushed last time: replace it first
    if (active_next && overflow_next && seq_len_next == 3'd1) begin
      run            = emit_byte(run, REPL_HI);
      run            = emit_byte(run, REPL_LO);
      active_next    = 1'b0;
      seq_len_next   = '0;
      cont_left_next = '0;
      code_val_next  = '0;
      overflow_next  = 1'b0;
    end

    if (active_next && cont) begin
      if (seq_len_next < 3'd4) begin
        seq_buf_next[seq_len_next[1:0]] = data_byte;
        seq_len_next = seq_len_next + 3'd1;
      end else begin
        overflow_next = 1'b1;
      end
      code_val_next = {code_val_next[14:0], data_byte[5:0]};
      if (cont_left_next != 3'd0) cont_left_next = cont_left_next - 3'd1;
    end else begin
      if (active_next) begin
        run = flush_run(run, seq_buf_next, seq_len_next, cont_left_next,
                        code_val_next, overflow_next);
        active_next    = 1'b0;
        seq_len_next   = '0;
        cont_left_next = '0;
        code_val_next  = '0;
        overflow_next  = 1'b0;
      end
      if (!data_byte[7]) begin
        if (data_byte != 8'h00) run = emit_byte(run, data_byte);
      end else begin
        active_next     = 1'b1;
        seq_buf_next[0] = data_byte;
        seq_len_next    = 3'd1;
        overflow_next   = 1'b0;
        if (data_byte[7:5] == 3'b110) begin
          code_val_next  = {16'd0, data_byte[4:0]};
          cont_left_next = 3'd2;
        end else if (data_byte[7:4] == 4'b1110) begin
          code_val_next  = {17'd0, data_byte[3:0]};
          cont_left_next = 3'd3;
        end else if (data_byte[7:3] == 5'b11110) begin
          code_val_next  = {18'd0, data_byte[2:0]};
          cont_left_next = 3'd4;
        end else begin
          code_val_next  = '0;
          cont_left_next = 3'd0;
        end
      end
    end

    if (end_of_stream && active_next) begin
      // No room for two more bytes in the run: hold the lone lead for next time
      if (run.count > RUN_CNT_W'(RUN_MAX - 2) && seq_len_next == 3'd1) begin
        overflow_next = 1'b1;
      end else begin
        run = flush_run(run, seq_buf_next, seq_len_next, cont_left_next,
                        code_val_next, overflow_next);
        active_next    = 1'b0;
        seq_len_next   = '0;
        cont_left_next = '0;
        code_val_next  = '0;
        overflow_next  = 1'b0;
      end
    end
  end

  assign push     = take && (run.count != '0);
  assign push_run = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      seq_len   <= '0;
      cont_left <= '0;
      code_val  <= '0;
      overflow  <= 1'b0;
    end else if (take) begin
      active    <= active_next;
      seq_len   <= seq_len_next;
      cont_left <= cont_left_next;
      code_val  <= code_val_next;
      overflow  <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) seq_buf <= seq_buf_next;
  end

endmodule

/* design/utfs_queue.sv */
module utfs_queue #(
  parameter int DEPTH = utfs_pkg::QUEUE_DEPTH_D
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  utfs_pkg::run_t push_run,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output utfs_pkg::run_t head_run
);
  import utfs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign full     = fill == CNT_W'(DEPTH);
  assign empty    = fill == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_run = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* design/utfs_back.sv */
module utfs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  utfs_pkg::run_t head_run,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           last_of_run
);
  import utfs_pkg::*;

  logic [RUN_CNT_W-1:0] idx;
  logic                 sent;

  assign out_valid   = !q_empty;
  assign out_byte    = head_run.bytes[idx];
  assign last_of_run = idx == (head_run.count - RUN_CNT_W'(1));
  assign sent        = out_valid && out_ready;
  assign pop         = sent && last_of_run;

  // Walk through the head run one byte per transaction, then release it
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (sent) begin
      idx <= last_of_run ? '0 : idx + RUN_CNT_W'(1);
    end
  end

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import utfs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX = 10;

  localparam logic TYPED = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    logic [7:0]      b;
    logic            eos;
    logic            typed;
    logic [2:0]      n;
    logic [0:4][7:0] bytes;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } out_beat_t;

  localparam int N_DIRECTED = 25;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{8'h41, 1'b0, TYPED, 3'd1, {8'h41, 32'h0}},
    '{8'h00, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'h7F, 1'b0, TYPED, 3'd1, {8'h7F, 32'h0}},
    '{8'hC3, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'hA9, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'h41, 1'b1, TYPED, 3'd3, {8'hC3, 8'hA9, 8'h41, 16'h0}},
    // stray continuation opens a bad sequence
    '{8'h80, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'h42, 1'b0, TYPED, 3'd3, {REPL_HI, REPL_LO, 8'h42, 16'h0}},
    '{8'hE2, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'h82, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'hAC, 1'b1, TYPED, 3'd3, {8'hE2, 8'h82, 8'hAC, 16'h0}},
    // fifth byte of a sequence overflows the buffer
    '{8'hF0, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'h90, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'h80, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'h80, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'h80, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'hFF, 1'b1, PREDICTED, 3'd0, 40'h0},
    // top code point, then a lead at end of stream that exceeds the run limit
    '{8'hF4, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'h8F, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'hBF, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'hBF, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'hC1, 1'b1, TYPED, 3'd4, {8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00}},
    '{8'hBF, 1'b1, PREDICTED, 3'd0, 40'h0},
    // overlong two-byte form
    '{8'hC1, 1'b0, TYPED, 3'd0, 40'h0},
    '{8'h81, 1'b1, TYPED, 3'd2, {REPL_HI, REPL_LO, 24'h0}}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_run;

  utf8_sanitizer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_stream(end_of_stream),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Pending multi-byte sequence as the block should hold it
  logic            pend_open = 1'b0;
  logic [0:3][7:0] pend_bytes = '0;
  logic [2:0]      pend_len = '0;
  logic [2:0]      conts_due = '0;
  logic [20:0]     code_acc = '0;
  logic            pend_over = 1'b0;
  logic [7:0]      run_bytes [RUN_MAX];
  int              run_n;

  out_beat_t expected_out [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        in_idle_pct = 0;
  int        out_stall_pct = 0;
  logic      pressure = 1'b0;
  int        hold_left = 0;
  logic      hold_taken = 1'b0;

  task automatic put_byte(input logic [7:0] b);
    if (run_n < RUN_MAX) begin
      run_bytes[run_n] = b;
      run_n++;
    end
  endtask

  task automatic queue_expected(input logic [7:0] b, input logic last);
    out_beat_t beat;
    beat.b       = b;
    beat.last    = last;
    expected_out = {expected_out, beat};
  endtask

  task automatic flush_pending();
    int k;
    if (conts_due == 3'd1 && !pend_over && code_acc >= CODE_MIN && code_acc <= CODE_MAX) begin
      for (k = 0; k < pend_len; k++) put_byte(pend_bytes[k]);
    end else begin
      put_byte(REPL_HI);
      put_byte(REPL_LO);
    end
    pend_open = 1'b0;
    pend_len  = '0;
    conts_due = '0;
    code_acc  = '0;
    pend_over = 1'b0;
  endtask

  task automatic sanitize_step(input logic [7:0] b, input logic eos);
    run_n = 0;
    // a lead held back by the run limit goes out first
    if (pend_open && pend_over && pend_len == 3'd1) flush_pending();
    if (pend_open && (b & CONT_MASK) == CONT_MARK) begin
      if (pend_len < 3'd4) begin
        pend_bytes[pend_len[1:0]] = b;
        pend_len++;
      end else begin
        pend_over = 1'b1;
      end
      code_acc = {code_acc[14:0], b[5:0]};
      if (conts_due != 3'd0) conts_due--;
    end else begin
      if (pend_open) flush_pending();
      if (!b[7]) begin
        if (b != 8'h00) put_byte(b);
      end else begin
        pend_open     = 1'b1;
        pend_bytes[0] = b;
        pend_len      = 3'd1;
        pend_over     = 1'b0;
        casez (b)
          8'b110?????: begin
            code_acc  = 21'(b[4:0]);
            conts_due = 3'd2;
          end
          8'b1110????: begin
            code_acc  = 21'(b[3:0]);
            conts_due = 3'd3;
          end
          8'b11110???: begin
            code_acc  = 21'(b[2:0]);
            conts_due = 3'd4;
          end
          default: begin
            code_acc  = '0;
            conts_due = 3'd0;
          end
        endcase
      end
    end
    if (eos && pend_open) begin
      if (run_n + 2 > RUN_MAX && pend_len == 3'd1) pend_over = 1'b1;
      else flush_pending();
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic eos, input logic typed,
                           input logic [2:0] typed_n, input logic [0:4][7:0] typed_bytes);
    int k;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sanitize_step(b, eos);
    if (typed) begin
      for (k = 0; k < typed_n; k++) queue_expected(typed_bytes[k], k == typed_n - 1);
    end else begin
      for (k = 0; k < run_n; k++) queue_expected(run_bytes[k], k == run_n - 1);
    end
  endtask

  function automatic logic [7:0] cont_byte();
    return CONT_MARK | 8'($urandom_range(0, 63));
  endfunction

  // Mostly well-formed sequences with random payload; the rest is noise and broken runs
  task automatic send_random_sequence(inout int sent);
    logic [7:0] seq [0:7];
    int         seq_n;
    int         kind;
    int         k;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      seq[0] = 8'($urandom_range(0, 127));
      seq_n  = 1;
    end else if (kind < 45) begin
      seq[0] = 8'($urandom_range(8'hC0, 8'hDF));
      seq_n  = 2;
    end else if (kind < 60) begin
      seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
      seq_n  = 3;
    end else if (kind < 75) begin
      seq[0] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8'hF5, 8'hF7))
                                           : 8'($urandom_range(8'hF0, 8'hF4));
      seq_n  = 4;
    end else if (kind < 85) begin
      seq_n = $urandom_range(1, 4);
    end else begin
      seq[0] = 8'($urandom_range(8'h80, 8'hFF));
      seq_n  = $urandom_range(1, 7);
    end
    for (k = 0; k < seq_n; k++) begin
      if (kind >= 75 && kind < 85) seq[k] = 8'($urandom_range(0, 255));
      else if (k > 0) seq[k] = cont_byte();
    end
    for (k = 0; k < seq_n; k++) begin
      send_item(seq[k], $urandom_range(0, 24) == 0, PREDICTED, 3'd0, 40'h0);
      sent++;
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_bytes);
    int sent;
    sent          = 0;
    in_idle_pct   = idle_pct;
    out_stall_pct <= stall_pct;
    while (sent < n_bytes) send_random_sequence(sent);
  endtask

  task automatic report_mismatch(input string what, input out_beat_t want);
    if (mismatches < REPORT_MAX)
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $realtime, what, want.b, want.last, out_byte, last_of_run);
    mismatches++;
  endtask

  always @(posedge clk) begin : receiver
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        report_mismatch("unexpected transaction", '0);
      end else begin
        want = expected_out.pop_front();
        if (want.b !== out_byte || want.last !== last_of_run)
          report_mismatch("mismatch", want);
      end
    end
    // hold off the output for a long stretch once, so the input backs up
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (pressure && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= out_stall_pct;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int i;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < N_DIRECTED; i++)
      send_item(DIRECTED[i].b, DIRECTED[i].eos, DIRECTED[i].typed, DIRECTED[i].n,
                DIRECTED[i].bytes);
    run_phase(0, 0, 90);
    run_phase(52, 0, 90);
    run_phase(0, 52, 90);
    pressure <= 1'b1;
    run_phase(0, 0, 40);
    pressure <= 1'b0;
    run_phase(31, 31, 90);
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* utf8_sanitizer.f */
design/utfs_pkg.sv
design/utfs_front.sv
design/utfs_queue.sv
design/utfs_back.sv
design/utf8_sanitizer.sv
tb/testbench.sv
